/* rtl/rfsa_pkg.sv */
// Shared types and constants of the radius falloff splat accumulator.
`timescale 1ns / 1ps
package rfsa_pkg;

  localparam int VERTEX_DEPTH_DEF = 4096;

  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_CLEAR   = 2'd1;
  localparam logic [1:0] ACT_CHANNEL = 2'd2;
  localparam logic [1:0] ACT_READ    = 2'd3;

  localparam logic [1:0] CFG_RADIUS       = 2'd0;
  localparam logic [1:0] CFG_USE_HBR      = 2'd1;
  localparam logic [1:0] CFG_VERTEX_COUNT = 2'd2;

  localparam logic [11:0] RADIUS_RESET = 12'd256;
  localparam logic [4:0]  SQRT_STEPS   = 5'd20;
  localparam logic [4:0]  DIV_STEPS    = 5'd27;

  typedef struct packed {
    logic capture;
    logic load_wr;
    logic ptr_clr;
    logic ptr_inc;
    logic clr_wr;
    logic rd_issue;
    logic out_load;
    logic fetch;
    logic square;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic mul;
    logic acc_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic ptr_last;
    logic walk_none;
    logic walk_last;
    logic step_last;
    logic in_radius;
    logic out_free;
  } dp_sts_t;

endpackage

/* rtl/radius_falloff_splat_accumulator_top.sv */
// Top level of the radius falloff splat accumulator.
// A load beat is written from idle; a read beat passes the read and result states,
// waiting in the latter while the result register is held. A clear beat, and the
// clearing pass after reset, sweep the activity memory one entry a cycle; no beat is
// taken until the sweep is done. A channel beat walks min(vertex_count, VERTEX_DEPTH)
// vertices one at a time, each through the bit-serial square root (21 steps) and, if
// inside the radius, the restoring divider (28 steps); with zero radius or count, none.
`timescale 1ns / 1ps
module radius_falloff_splat_accumulator_top #(
  parameter int VERTEX_DEPTH = rfsa_pkg::VERTEX_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_action,
  input  logic [11:0]        in_vertex_index,
  input  logic signed [19:0] in_pos_x,
  input  logic signed [19:0] in_pos_y,
  input  logic signed [19:0] in_pos_z,
  input  logic signed [23:0] in_hbo_value,
  input  logic signed [23:0] in_hbr_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [11:0]        out_read_index,
  output logic signed [31:0] out_activity,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_wdata
);

  rfsa_pkg::dp_cmd_t cmd;
  rfsa_pkg::dp_sts_t sts;

  rfsa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  rfsa_dp #(
    .VERTEX_DEPTH (VERTEX_DEPTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_vertex_index (in_vertex_index),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_hbo_value    (in_hbo_value),
    .in_hbr_value    (in_hbr_value),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_read_index  (out_read_index),
    .out_activity    (out_activity)
  );

endmodule

/* rtl/rfsa_ctrl.sv */
// Sequencer that steps the datapath through load, clear, channel walk and read.
`timescale 1ns / 1ps
module rfsa_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [1:0]         in_action,
  output logic               in_stall,
  input  rfsa_pkg::dp_sts_t  sts,
  output rfsa_pkg::dp_cmd_t  cmd
);

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_RDOUT = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_SQ    = 4'd5;
  localparam logic [3:0] S_SUM   = 4'd6;
  localparam logic [3:0] S_SQRT  = 4'd7;
  localparam logic [3:0] S_CMP   = 4'd8;
  localparam logic [3:0] S_DIV   = 4'd9;
  localparam logic [3:0] S_MUL   = 4'd10;
  localparam logic [3:0] S_ACC   = 4'd11;
  localparam logic [3:0] S_NEXT  = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        if (sts.ptr_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          case (in_action)
            rfsa_pkg::ACT_LOAD: cmd.load_wr = 1'b1;
            rfsa_pkg::ACT_CLEAR: begin
              cmd.ptr_clr = 1'b1;
              state_nxt   = S_CLR;
            end
            rfsa_pkg::ACT_CHANNEL: begin
              cmd.ptr_clr = 1'b1;
              if (!sts.walk_none) state_nxt = S_FETCH;
            end
            default: state_nxt = S_RD;
          endcase
        end
      end
      S_RD: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = S_RDOUT;
      end
      S_RDOUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_SQ;
      end
      S_SQ: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sqrt_init = 1'b1;
        state_nxt     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.step_last) state_nxt = S_CMP;
      end
      S_CMP: begin
        if (sts.in_radius) begin
          cmd.div_init = 1'b1;
          state_nxt    = S_DIV;
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.step_last) state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ACC;
      end
      S_ACC: begin
        cmd.acc_wr = 1'b1;
        state_nxt  = S_NEXT;
      end
      S_NEXT: begin
        if (sts.walk_last) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.ptr_inc = 1'b1;
          state_nxt   = S_FETCH;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

/* rtl/rfsa_dp.sv */
// Datapath: vertex and activity memories, distance, square root, divider, accumulator.
`timescale 1ns / 1ps
module rfsa_dp #(
  parameter int VERTEX_DEPTH = rfsa_pkg::VERTEX_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  rfsa_pkg::dp_cmd_t   cmd,
  output rfsa_pkg::dp_sts_t   sts,
  input  logic [11:0]         in_vertex_index,
  input  logic signed [19:0]  in_pos_x,
  input  logic signed [19:0]  in_pos_y,
  input  logic signed [19:0]  in_pos_z,
  input  logic signed [23:0]  in_hbo_value,
  input  logic signed [23:0]  in_hbr_value,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [12:0]         cfg_wdata,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [11:0]         out_read_index,
  output logic signed [31:0]  out_activity
);

  localparam int AW = (VERTEX_DEPTH > 1) ? $clog2(VERTEX_DEPTH) : 1;
  localparam int CW = $clog2(VERTEX_DEPTH + 1);
  localparam logic [11:0] RADIUS_RESET_C = rfsa_pkg::RADIUS_RESET;

  logic [11:0] radius_r;
  logic        use_hbr_r;
  logic [12:0] count_r;

  logic signed [19:0] mem_x [VERTEX_DEPTH];
  logic signed [19:0] mem_y [VERTEX_DEPTH];
  logic signed [19:0] mem_z [VERTEX_DEPTH];
  logic signed [31:0] mem_a [VERTEX_DEPTH];

  logic [AW-1:0]      ptr_r;
  logic signed [19:0] px_r, py_r, pz_r;
  logic signed [23:0] value_r;
  logic [11:0]        idx_r;
  logic               idx_ok_r;
  logic signed [19:0] vx_r, vy_r, vz_r;
  logic signed [31:0] act_r;
  logic [41:0]        sqx_r, sqy_r, sqz_r;
  logic [41:0]        rem_r, res_r;
  logic [4:0]         step_r;
  logic [27:0]        quo_r;
  logic [11:0]        drem_r;
  logic signed [41:0] prod_r;
  logic               out_valid_r;
  logic [11:0]        out_index_r;
  logic signed [31:0] out_act_r;

  logic [CW-1:0]      neff;
  logic               in_idx_ok;
  logic signed [20:0] dx, dy, dz;
  logic signed [41:0] sqx, sqy, sqz;
  logic [41:0]        bitv, trial_s;
  logic [12:0]        trial_d;
  logic [16:0]        falloff;
  logic signed [41:0] prod;
  logic signed [25:0] gain;
  logic signed [32:0] sum33;
  logic signed [31:0] acc_nxt;

  always_comb begin
    if (32'(count_r) > VERTEX_DEPTH) neff = CW'(VERTEX_DEPTH);
    else neff = CW'(count_r);
  end

  assign in_idx_ok = (32'(in_vertex_index) < VERTEX_DEPTH);

  assign sts.ptr_last  = (ptr_r == AW'(VERTEX_DEPTH - 1));
  assign sts.walk_none = (radius_r == 12'd0) || (neff == '0);
  assign sts.walk_last = ((CW'(ptr_r) + CW'(1)) == neff);
  assign sts.step_last = (step_r == 5'd0);
  assign sts.in_radius = (res_r <= {30'd0, radius_r});
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign dx  = {px_r[19], px_r} - {vx_r[19], vx_r};
  assign dy  = {py_r[19], py_r} - {vy_r[19], vy_r};
  assign dz  = {pz_r[19], pz_r} - {vz_r[19], vz_r};
  assign sqx = dx * dx;
  assign sqy = dy * dy;
  assign sqz = dz * dz;

  assign bitv    = 42'(1) << {step_r, 1'b0};
  assign trial_s = res_r + bitv;
  assign trial_d = {drem_r, quo_r[27]};

  assign falloff = 17'h10000 - quo_r[16:0];
  assign prod    = value_r * $signed({1'b0, falloff});
  assign gain    = prod_r[41:16];
  assign sum33   = {act_r[31], act_r} + {{7{gain[25]}}, gain};

  always_comb begin
    case (sum33[32:31])
      2'b01:   acc_nxt = 32'sh7FFFFFFF;
      2'b10:   acc_nxt = -32'sh80000000;
      default: acc_nxt = sum33[31:0];
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= RADIUS_RESET_C;
      use_hbr_r <= 1'b0;
      count_r   <= 13'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        rfsa_pkg::CFG_RADIUS:       radius_r  <= cfg_wdata[11:0];
        rfsa_pkg::CFG_USE_HBR:      use_hbr_r <= cfg_wdata[0];
        rfsa_pkg::CFG_VERTEX_COUNT: count_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_wr && in_idx_ok) begin
      mem_x[AW'(in_vertex_index)] <= in_pos_x;
      mem_y[AW'(in_vertex_index)] <= in_pos_y;
      mem_z[AW'(in_vertex_index)] <= in_pos_z;
    end
    if (cmd.fetch) begin
      vx_r <= mem_x[ptr_r];
      vy_r <= mem_y[ptr_r];
      vz_r <= mem_z[ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_wr) mem_a[ptr_r] <= '0;
    else if (cmd.acc_wr) mem_a[ptr_r] <= acc_nxt;
    if (cmd.fetch) act_r <= mem_a[ptr_r];
    else if (cmd.rd_issue) act_r <= mem_a[AW'(idx_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r <= '0;
    end else if (cmd.ptr_clr) begin
      ptr_r <= '0;
    end else if (cmd.clr_wr || cmd.ptr_inc) begin
      ptr_r <= ptr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      px_r     <= in_pos_x;
      py_r     <= in_pos_y;
      pz_r     <= in_pos_z;
      value_r  <= use_hbr_r ? in_hbr_value : in_hbo_value;
      idx_r    <= in_vertex_index;
      idx_ok_r <= in_idx_ok;
    end
    if (cmd.square) begin
      sqx_r <= sqx;
      sqy_r <= sqy;
      sqz_r <= sqz;
    end
    if (cmd.sqrt_init) begin
      rem_r  <= sqx_r + sqy_r + sqz_r;
      res_r  <= '0;
      step_r <= rfsa_pkg::SQRT_STEPS;
    end else if (cmd.sqrt_step) begin
      if (rem_r >= trial_s) begin
        rem_r <= rem_r - trial_s;
        res_r <= (res_r >> 1) + bitv;
      end else begin
        res_r <= res_r >> 1;
      end
      step_r <= step_r - 5'd1;
    end else if (cmd.div_init) begin
      quo_r  <= {res_r[11:0], 16'd0};
      drem_r <= '0;
      step_r <= rfsa_pkg::DIV_STEPS;
    end else if (cmd.div_step) begin
      if (trial_d >= {1'b0, radius_r}) begin
        drem_r <= 12'(trial_d - {1'b0, radius_r});
        quo_r  <= {quo_r[26:0], 1'b1};
      end else begin
        drem_r <= trial_d[11:0];
        quo_r  <= {quo_r[26:0], 1'b0};
      end
      step_r <= step_r - 5'd1;
    end
    if (cmd.mul) prod_r <= prod;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_index_r <= idx_r;
      out_act_r   <= idx_ok_r ? act_r : 32'sd0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_index = out_index_r;
  assign out_activity   = out_act_r;

`ifndef SYNTHESIS
  a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.clr_wr && cmd.acc_wr))
    else $error("activity memory written by clear and accumulate at once");

  a_quotient_fits: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul |-> (quo_r[27:17] == 11'd0))
    else $error("falloff quotient exceeds one");

  a_out_from_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.out_load))
    else $error("result beat raised without a read");
`endif

endmodule

/* verif/tb_radius_falloff_splat_accumulator_top.sv */
// Self-checking testbench for the radius falloff splat accumulator top level.
`timescale 1ns / 1ps
module tb_radius_falloff_splat_accumulator_top;

  localparam int DEPTH = 4096;
  localparam int IDLE_LIMIT = 400000;

  typedef struct {
    logic [1:0]         action;
    logic [11:0]        vidx;
    logic signed [19:0] px;
    logic signed [19:0] py;
    logic signed [19:0] pz;
    logic signed [23:0] hbo;
    logic signed [23:0] hbr;
  } beat_t;

  typedef struct {
    logic [11:0]        vidx;
    logic signed [31:0] act;
  } readback_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_action = rfsa_pkg::ACT_LOAD;
  logic [11:0]        in_vertex_index = '0;
  logic signed [19:0] in_pos_x = '0;
  logic signed [19:0] in_pos_y = '0;
  logic signed [19:0] in_pos_z = '0;
  logic signed [23:0] in_hbo_value = '0;
  logic signed [23:0] in_hbr_value = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [11:0]        out_read_index;
  logic signed [31:0] out_activity;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_index = rfsa_pkg::CFG_RADIUS;
  logic [12:0]        cfg_wdata = '0;

  radius_falloff_splat_accumulator_top dut (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  beat_t     pending_beats[$];
  readback_t expected_reads[$];
  beat_t     cur_beat;
  int        vert_x[DEPTH];
  int        vert_y[DEPTH];
  int        vert_z[DEPTH];
  int        activity[DEPTH];
  int        sh_radius = 256;
  int        sh_use_hbr = 0;
  int        sh_count = 0;
  int        errors = 0;
  int        idle_cycles = 0;
  int        in_gap = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;
  bit        in_fired;

  task automatic report(input string msg);
    $display("MISMATCH: %s", msg);
    errors++;
  endtask

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic void splat_channel(input beat_t b);
    longint dx, dy, dz, val, falloff, acc;
    longint unsigned span_d;
    int n;
    if (sh_radius == 0) return;
    n = (sh_count > DEPTH) ? DEPTH : sh_count;
    val = sh_use_hbr ? longint'(b.hbr) : longint'(b.hbo);
    for (int i = 0; i < n; i++) begin
      dx = longint'(b.px) - vert_x[i];
      dy = longint'(b.py) - vert_y[i];
      dz = longint'(b.pz) - vert_z[i];
      span_d = floor_root(longint'(dx * dx + dy * dy + dz * dz));
      if (span_d > longint'(sh_radius)) continue;
      falloff = 65536 - longint'((span_d << 16) / sh_radius);
      acc = longint'(activity[i]) + ((val * falloff) >>> 16);
      if (acc > 64'sd2147483647) acc = 64'sd2147483647;
      if (acc < -64'sd2147483648) acc = -64'sd2147483648;
      activity[i] = int'(acc);
    end
  endfunction

  function automatic void apply_beat(input beat_t b);
    readback_t r;
    case (b.action)
      rfsa_pkg::ACT_LOAD: begin
        vert_x[b.vidx] = int'(b.px);
        vert_y[b.vidx] = int'(b.py);
        vert_z[b.vidx] = int'(b.pz);
      end
      rfsa_pkg::ACT_CLEAR: foreach (activity[i]) activity[i] = 0;
      rfsa_pkg::ACT_CHANNEL: splat_channel(b);
      default: begin
        r.vidx = b.vidx;
        r.act = activity[b.vidx];
        expected_reads.insert(expected_reads.size(), r);
      end
    endcase
  endfunction

  always @(posedge clk) begin
    readback_t e;
    in_fired = rst_n && in_valid && (in_stall === 1'b0);
    if (in_fired) apply_beat(cur_beat);
    if (rst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (expected_reads.size() == 0) begin
        report($sformatf("unexpected read beat index %0d", out_read_index));
      end else begin
        e = expected_reads.pop_front();
        if (out_read_index !== e.vidx)
          report($sformatf("read_index %0d, expected %0d", out_read_index, e.vidx));
        if (out_activity !== e.act)
          report($sformatf("activity of %0d is %0d, expected %0d",
                           e.vidx, out_activity, e.act));
      end
      idle_cycles = 0;
    end else if (in_fired) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  always @(negedge clk) begin
    if (!(in_valid && !in_fired)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (rst_n && pending_beats.size() > 0) begin
        cur_beat = pending_beats.pop_front();
        in_action <= cur_beat.action;
        in_vertex_index <= cur_beat.vidx;
        in_pos_x <= cur_beat.px;
        in_pos_y <= cur_beat.py;
        in_pos_z <= cur_beat.pz;
        in_hbo_value <= cur_beat.hbo;
        in_hbr_value <= cur_beat.hbr;
        in_valid <= 1'b1;
        in_gap = next_gap();
      end else begin
        in_valid <= 1'b0;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 3) == 0) stall_left = next_gap();
    end
  end

  task automatic push(input logic [1:0] act, input int idx, input int x, input int y,
                      input int z, input int hbo, input int hbr);
    beat_t b;
    b.action = act;
    b.vidx = 12'(idx);
    b.px = 20'(x);
    b.py = 20'(y);
    b.pz = 20'(z);
    b.hbo = 24'(hbo);
    b.hbr = 24'(hbr);
    pending_beats.insert(pending_beats.size(), b);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= 13'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      rfsa_pkg::CFG_RADIUS: sh_radius = val & 12'hFFF;
      rfsa_pkg::CFG_USE_HBR: sh_use_hbr = val & 1;
      default: sh_count = val & 13'h1FFF;
    endcase
  endtask

  task automatic drain();
    while (!(pending_beats.size() == 0 && !in_valid && expected_reads.size() == 0))
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic int near(input int c, input int span);
    return c + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic int rnd24();
    return int'($urandom_range(0, 24'hFFFFFF)) - 8388608;
  endfunction

  task automatic random_phase(input int n);
    int r, cx, cy, cz, span;
    span = (sh_radius > 16) ? sh_radius : 16;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(0, 99);
      cx = vert_x[$urandom_range(0, 15)];
      cy = vert_y[$urandom_range(0, 15)];
      cz = vert_z[$urandom_range(0, 15)];
      if (r < 15)
        push(rfsa_pkg::ACT_LOAD, $urandom_range(0, 15), near(0, 600), near(0, 600),
             near(0, 600), rnd24(), rnd24());
      else if (r < 20)
        push(rfsa_pkg::ACT_LOAD, $urandom_range(16, 4095),
             int'($urandom_range(0, 20'hFFFFF)) - 524288,
             int'($urandom_range(0, 20'hFFFFF)) - 524288,
             int'($urandom_range(0, 20'hFFFFF)) - 524288, rnd24(), rnd24());
      else if (r < 23)
        push(rfsa_pkg::ACT_CLEAR, $urandom_range(0, 4095), near(0, 9), 0, 0, rnd24(),
             rnd24());
      else if (r < 55)
        push(rfsa_pkg::ACT_CHANNEL, $urandom_range(0, 4095), near(cx, span),
             near(cy, span), near(cz, span), rnd24(), rnd24());
      else if (r < 60)
        push(rfsa_pkg::ACT_CHANNEL, 0, int'($urandom_range(0, 20'hFFFFF)) - 524288,
             int'($urandom_range(0, 20'hFFFFF)) - 524288,
             int'($urandom_range(0, 20'hFFFFF)) - 524288, rnd24(), rnd24());
      else if (r < 90)
        push(rfsa_pkg::ACT_READ, $urandom_range(0, 15), 0, 0, 0, 0, 0);
      else
        push(rfsa_pkg::ACT_READ, $urandom_range(0, 4095), near(0, 9), 0, 0, rnd24(),
             rnd24());
    end
    push(rfsa_pkg::ACT_READ, $urandom_range(0, 15), 0, 0, 0, 0, 0);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 15; i++)
      push(rfsa_pkg::ACT_LOAD, i, i * 40, -i * 30, i * 20, 0, 0);
    push(rfsa_pkg::ACT_LOAD, 15, -524288, 524287, -524288, 8388607, -8388608);
    push(rfsa_pkg::ACT_CHANNEL, 0, 0, 0, 0, 8388607, -8388608);
    push(rfsa_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    push(rfsa_pkg::ACT_READ, 4095, 0, 0, 0, 0, 0);
    drain();

    write_reg(rfsa_pkg::CFG_VERTEX_COUNT, 16);
    write_reg(rfsa_pkg::CFG_RADIUS, 2560);
    push(rfsa_pkg::ACT_CHANNEL, 0, 0, 0, 0, 8388607, -8388608);
    push(rfsa_pkg::ACT_CHANNEL, 0, 524287, -524288, 524287, -8388608, 8388607);
    push(rfsa_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    push(rfsa_pkg::ACT_READ, 5, 0, 0, 0, 0, 0);
    push(rfsa_pkg::ACT_READ, 15, 0, 0, 0, 0, 0);
    drain();

    write_reg(rfsa_pkg::CFG_USE_HBR, 1);
    write_reg(rfsa_pkg::CFG_RADIUS, 1);
    push(rfsa_pkg::ACT_CHANNEL, 0, 40, -30, 20, 8388607, -8388608);
    push(rfsa_pkg::ACT_READ, 1, 0, 0, 0, 0, 0);
    drain();

    write_reg(rfsa_pkg::CFG_RADIUS, 0);
    push(rfsa_pkg::ACT_CHANNEL, 0, 0, 0, 0, 8388607, 8388607);
    push(rfsa_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    push(rfsa_pkg::ACT_CLEAR, 0, 0, 0, 0, 0, 0);
    push(rfsa_pkg::ACT_READ, 0, 0, 0, 0, 0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2);
      write_reg(rfsa_pkg::CFG_RADIUS, (ph == 4) ? 2560 : $urandom_range(1, 1200));
      write_reg(rfsa_pkg::CFG_USE_HBR, $urandom_range(0, 1));
      write_reg(rfsa_pkg::CFG_VERTEX_COUNT, (ph == 5) ? 0 : $urandom_range(1, 16));
      random_phase(18);
      drain();
    end
    calm = 1'b0;

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
